// File: rtl/core/indexed_ordered_list_assert.svh
// Assertion macros for the indexed ordered list block.
`ifndef INDEXED_ORDERED_LIST_ASSERT_SVH
`define INDEXED_ORDERED_LIST_ASSERT_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define ILST_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("ilst assertion failed");
// next-cycle implication
`define ILST_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("ilst assertion failed");
`else
`define ILST_ASSERT_IMPL(lbl, clk, rstn, ante, cons)
`define ILST_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif

`endif

// File: rtl/core/ilst_pkg.sv
// Types and constants shared by the indexed ordered list modules.
package ilst_pkg;

    localparam int LIST_DEPTH = 16;
    localparam int ADDR_W     = $clog2(LIST_DEPTH);
    localparam int FUNC_W     = 3;
    localparam int VALUE_W    = 32;
    localparam int INDEX_W    = 5;
    localparam int STATUS_W   = 2;
    localparam int LENGTH_W   = 5;
    localparam int S_TDATA_W  = 40;
    localparam int M_TDATA_W  = 40;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_PUSH   = 3'd0,
        FUNC_POP    = 3'd1,
        FUNC_INSERT = 3'd2,
        FUNC_REMOVE = 3'd3,
        FUNC_DUMP   = 3'd4
    } func_t;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK    = 2'd0,
        STAT_FULL  = 2'd1,
        STAT_EMPTY = 2'd2,
        STAT_RANGE = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INS_SHIFT,
        ST_INS_PUT,
        ST_REM_SHIFT,
        ST_RESP,
        ST_DUMP_RD,
        ST_DUMP_OUT
    } state_t;

    typedef struct packed {
        status_t                     status;
        logic [LENGTH_W-1:0]         length;
        logic signed [VALUE_W-1:0]   elem_value;
        logic                        elem_valid;
        logic                        last;
    } result_t;

endpackage

// File: rtl/core/ilst_ram.sv
// Single-port-write, single-port-read element memory with registered read data.
module ilst_ram #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 32,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk) begin
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

// File: rtl/core/ilst_ctrl.sv
// Operation sequencer: decodes items, shifts entries through the memory, runs dumps.
module ilst_ctrl import ilst_pkg::*; (
    input  logic                      clk,
    input  logic                      rstn,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  func_t                     in_func,
    input  logic signed [VALUE_W-1:0] in_value,
    input  logic [INDEX_W-1:0]        in_index,
    output logic                      ram_we,
    output logic [ADDR_W-1:0]         ram_waddr,
    output logic [VALUE_W-1:0]        ram_wdata,
    output logic                      ram_re,
    output logic [ADDR_W-1:0]         ram_raddr,
    input  logic [VALUE_W-1:0]        ram_rdata,
    input  logic                      out_free,
    output logic                      out_load,
    output result_t                   out_data
);

    state_t                    state_reg, state_next;
    logic [LENGTH_W-1:0]       count_reg, count_next;
    logic [ADDR_W-1:0]         ptr_reg, ptr_next;
    logic [ADDR_W-1:0]         pos_reg, pos_next;
    logic [VALUE_W-1:0]        val_reg, val_next;
    status_t                   status_reg, status_next;

    logic                      accept;
    logic                      full;
    logic                      empty;
    logic [LENGTH_W-1:0]       last_idx;
    logic [LENGTH_W-1:0]       ins_pos;
    logic [LENGTH_W-1:0]       rem_pos;
    status_t                   ins_status;
    status_t                   rem_status;
    logic                      ptr_at_last;

    assign accept      = in_valid && (state_reg == ST_IDLE);
    assign full        = (count_reg == LENGTH_W'(LIST_DEPTH));
    assign empty       = (count_reg == '0);
    assign last_idx    = count_reg - LENGTH_W'(1);
    assign ins_pos     = (in_func == FUNC_PUSH) ? count_reg : LENGTH_W'(in_index);
    assign rem_pos     = (in_func == FUNC_POP) ? last_idx : LENGTH_W'(in_index);
    assign ptr_at_last = (LENGTH_W'(ptr_reg) == last_idx);

    always_comb begin
        priority if (full) begin
            ins_status = STAT_FULL;
        end else if (ins_pos > count_reg) begin
            ins_status = STAT_RANGE;
        end else begin
            ins_status = STAT_OK;
        end
    end

    always_comb begin
        priority if (empty) begin
            rem_status = STAT_EMPTY;
        end else if (rem_pos >= count_reg) begin
            rem_status = STAT_RANGE;
        end else begin
            rem_status = STAT_OK;
        end
    end

    always_ff @(posedge clk) begin
        if (!rstn) begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk) begin
        ptr_reg    <= ptr_next;
        pos_reg    <= pos_next;
        val_reg    <= val_next;
        status_reg <= status_next;
    end

    // next state
    always_comb begin
        state_next  = state_reg;
        count_next  = count_reg;
        ptr_next    = ptr_reg;
        pos_next    = pos_reg;
        val_next    = val_reg;
        status_next = status_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    unique case (in_func)
                        FUNC_PUSH, FUNC_INSERT: begin
                            if (ins_status != STAT_OK) begin
                                status_next = ins_status;
                                state_next  = ST_RESP;
                            end else begin
                                pos_next = ins_pos[ADDR_W-1:0];
                                val_next = in_value;
                                if (ins_pos == count_reg) begin
                                    state_next = ST_INS_PUT;
                                end else begin
                                    ptr_next   = last_idx[ADDR_W-1:0];
                                    state_next = ST_INS_SHIFT;
                                end
                            end
                        end
                        FUNC_POP, FUNC_REMOVE: begin
                            if (rem_status != STAT_OK) begin
                                status_next = rem_status;
                                state_next  = ST_RESP;
                            end else if (rem_pos == last_idx) begin
                                count_next  = last_idx;
                                status_next = STAT_OK;
                                state_next  = ST_RESP;
                            end else begin
                                ptr_next   = rem_pos[ADDR_W-1:0] + ADDR_W'(1);
                                state_next = ST_REM_SHIFT;
                            end
                        end
                        FUNC_DUMP: begin
                            if (empty) begin
                                status_next = STAT_OK;
                                state_next  = ST_RESP;
                            end else begin
                                ptr_next   = '0;
                                state_next = ST_DUMP_RD;
                            end
                        end
                        default: begin
                            status_next = STAT_OK;
                            state_next  = ST_RESP;
                        end
                    endcase
                end
            end
            ST_INS_SHIFT: begin
                if (ptr_reg == pos_reg) begin
                    state_next = ST_INS_PUT;
                end else begin
                    ptr_next = ptr_reg - ADDR_W'(1);
                end
            end
            ST_INS_PUT: begin
                count_next  = count_reg + LENGTH_W'(1);
                status_next = STAT_OK;
                state_next  = ST_RESP;
            end
            ST_REM_SHIFT: begin
                if (ptr_at_last) begin
                    count_next  = last_idx;
                    status_next = STAT_OK;
                    state_next  = ST_RESP;
                end else begin
                    ptr_next = ptr_reg + ADDR_W'(1);
                end
            end
            ST_RESP: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            ST_DUMP_RD: begin
                state_next = ST_DUMP_OUT;
            end
            ST_DUMP_OUT: begin
                if (out_free) begin
                    if (ptr_at_last) begin
                        state_next = ST_IDLE;
                    end else begin
                        ptr_next = ptr_reg + ADDR_W'(1);
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // outputs
    always_comb begin
        in_ready  = (state_reg == ST_IDLE);
        ram_raddr = ptr_next;
        ram_re    = (state_next == ST_INS_SHIFT) || (state_next == ST_REM_SHIFT) ||
                    (state_reg == ST_DUMP_RD) ||
                    ((state_reg == ST_DUMP_OUT) && out_free && !ptr_at_last);
        ram_we    = 1'b0;
        ram_waddr = ptr_reg;
        ram_wdata = ram_rdata;
        out_load  = 1'b0;
        out_data  = '{status: status_reg, length: count_reg, elem_value: '0,
                      elem_valid: 1'b0, last: 1'b1};
        unique case (state_reg)
            ST_INS_SHIFT: begin
                ram_we    = 1'b1;
                ram_waddr = ptr_reg + ADDR_W'(1);
            end
            ST_REM_SHIFT: begin
                ram_we    = 1'b1;
                ram_waddr = ptr_reg - ADDR_W'(1);
            end
            ST_INS_PUT: begin
                ram_we    = 1'b1;
                ram_waddr = pos_reg;
                ram_wdata = val_reg;
            end
            ST_RESP: begin
                out_load = out_free;
            end
            ST_DUMP_OUT: begin
                out_load = out_free;
                out_data = '{status: STAT_OK, length: count_reg, elem_value: ram_rdata,
                             elem_valid: 1'b1, last: ptr_at_last};
            end
            default: begin
                ram_we = 1'b0;
            end
        endcase
    end

endmodule

// File: rtl/core/ilst_out.sv
// Result output register with master-side stream handshake.
module ilst_out import ilst_pkg::*; (
    input  logic                 clk,
    input  logic                 rstn,
    input  logic                 load,
    input  result_t              data,
    output logic                 free,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,
    output logic                 m_tlast
);

    logic    valid_reg, valid_next;
    result_t data_reg;

    assign free = !valid_reg || m_tready;

    always_comb begin
        valid_next = valid_reg;
        if (load) begin
            valid_next = 1'b1;
        end else if (m_tready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk) begin
        if (!rstn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk) begin
        if (load) begin
            data_reg <= data;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {data_reg.elem_valid, data_reg.elem_value, data_reg.length,
                       data_reg.status};
    assign m_tlast  = data_reg.last;

endmodule

// File: rtl/core/indexed_ordered_list.sv
// Top level of the indexed ordered list: element memory, sequencer and output register.
//
//  channel | dir | tdata fields (low bit first)              | tlast
//  s_      | in  | func[2:0] value[34:3] index[39:35]        | -
//  m_      | out | status[1:0] length[6:2] elem_value[38:7]  | last
//          |     | elem_valid[39]                            |
//
// One item at a time. Push or insert at the tail writes the value, then the result;
// pop and errors send only the result. Insert and remove at index p move later entries
// by one memory write per shifted entry. Dump reads and sends each element in order.
// Synchronous reset clears length to zero; memory contents are not cleared.
// s_tready is low while an item is in work; m_tready low stalls the sequencer.
`include "indexed_ordered_list_assert.svh"

module indexed_ordered_list import ilst_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // func, value, index
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,   // status, length, elem_value, elem_valid
    output logic                 m_tlast
);

    logic                ram_we;
    logic [ADDR_W-1:0]   ram_waddr;
    logic [VALUE_W-1:0]  ram_wdata;
    logic                ram_re;
    logic [ADDR_W-1:0]   ram_raddr;
    logic [VALUE_W-1:0]  ram_rdata;
    logic                out_free;
    logic                out_load;
    result_t             out_data;

    ilst_ram #(
        .DEPTH (LIST_DEPTH),
        .WIDTH (VALUE_W)
    ) u_ram (
        .clk   (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    ilst_ctrl u_ctrl (
        .clk       (aclk),
        .rstn      (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_func   (func_t'(s_tdata[FUNC_W-1:0])),
        .in_value  (s_tdata[FUNC_W+VALUE_W-1:FUNC_W]),
        .in_index  (s_tdata[FUNC_W+VALUE_W+INDEX_W-1:FUNC_W+VALUE_W]),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .ram_re    (ram_re),
        .ram_raddr (ram_raddr),
        .ram_rdata (ram_rdata),
        .out_free  (out_free),
        .out_load  (out_load),
        .out_data  (out_data)
    );

    ilst_out u_out (
        .clk      (aclk),
        .rstn     (aresetn),
        .load     (out_load),
        .data     (out_data),
        .free     (out_free),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    `ILST_ASSERT_NEXT(a_busy_after_accept, aclk, aresetn, s_tvalid && s_tready, !s_tready)
    `ILST_ASSERT_IMPL(a_length_bound, aclk, aresetn, m_tvalid, m_tdata[6:2] <= LENGTH_W'(LIST_DEPTH))
    `ILST_ASSERT_IMPL(a_no_elem_zero, aclk, aresetn, m_tvalid && !m_tdata[39], m_tdata[38:7] == '0)
    `ILST_ASSERT_IMPL(a_nonlast_is_elem, aclk, aresetn, m_tvalid && !m_tlast, m_tdata[39])

endmodule

// File: dv/indexed_ordered_list_test.sv
`timescale 1ns / 1ps
// Testbench for indexed_ordered_list: directed table, then random list traffic checked by a predictor.
module indexed_ordered_list_test;
    import ilst_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int RANDOM_ITEMS = 320;
    localparam int MAX_SHOWN    = 10;
    localparam int SCRIPT_ROWS  = 19;
    localparam int DRAIN_CYCLES = 40;
    localparam logic [FUNC_W-1:0] FUNC_LAST = 3'd7;   // highest (unused) code

    typedef struct {
        logic [FUNC_W-1:0] func;
        int                value;
        int                index;
        int                reps;
        bit                fixed;
        status_t           status;
        int                length;
    } list_row_t;

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    logic                 m_tready = 1'b0;
    wire                  s_tready;
    wire                  m_tvalid;
    wire  [M_TDATA_W-1:0] m_tdata;
    wire                  m_tlast;

    // predictor state
    logic signed [VALUE_W-1:0] cells [LIST_DEPTH];
    int                        cell_count = 0;
    result_t                   due_results [$];

    // item on the input bus and its typed expectation, if any
    bit                        cur_fixed = 1'b0;
    result_t                   cur_fixed_res;

    int src_idle_pct  = 0;
    int sink_idle_pct = 0;
    int cycles        = 0;
    int mismatches    = 0;
    int items_taken   = 0;
    int dumps_taken   = 0;
    int results_seen  = 0;
    int error_results = 0;
    int deepest       = 0;

    list_row_t script [SCRIPT_ROWS];

    always #2 aclk = ~aclk;

    indexed_ordered_list dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),    // func, value, index
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),    // status, length, elem_value, elem_valid
        .m_tlast  (m_tlast)
    );

    function automatic status_t list_insert(input int pos, input logic signed [VALUE_W-1:0] v);
        int i;
        if (cell_count >= LIST_DEPTH) return STAT_FULL;
        if (pos > cell_count) return STAT_RANGE;
        for (i = cell_count; i > pos; i--) cells[i] = cells[i-1];
        cells[pos] = v;
        cell_count++;
        return STAT_OK;
    endfunction

    function automatic status_t list_remove(input int pos);
        int i;
        if (cell_count == 0) return STAT_EMPTY;
        if (pos >= cell_count) return STAT_RANGE;
        for (i = pos; i + 1 < cell_count; i++) cells[i] = cells[i+1];
        cell_count--;
        return STAT_OK;
    endfunction

    // applies one operation and queues the results it should produce
    function automatic void predict_item(input logic [FUNC_W-1:0] func,
                                         input logic signed [VALUE_W-1:0] value,
                                         input int index);
        result_t r;
        status_t st;
        int      i;
        st = STAT_OK;
        case (func)
            FUNC_PUSH:   st = list_insert(cell_count, value);
            FUNC_POP:    st = (cell_count == 0) ? STAT_EMPTY : list_remove(cell_count - 1);
            FUNC_INSERT: st = list_insert(index, value);
            FUNC_REMOVE: st = list_remove(index);
            FUNC_DUMP: begin
                if (cell_count == 0) begin
                    r = '{STAT_OK, '0, '0, 1'b0, 1'b1};
                    due_results.push_back(r);
                end else begin
                    for (i = 0; i < cell_count; i++) begin
                        r.status     = STAT_OK;
                        r.length     = LENGTH_W'(cell_count);
                        r.elem_value = cells[i];
                        r.elem_valid = 1'b1;
                        r.last       = (i + 1 == cell_count);
                        due_results.push_back(r);
                    end
                end
                return;
            end
            default: ;
        endcase
        r.status     = st;
        r.length     = LENGTH_W'(cell_count);
        r.elem_value = '0;
        r.elem_valid = 1'b0;
        r.last       = 1'b1;
        due_results.push_back(r);
    endfunction

    task automatic note_failure(input string what, input result_t want, input result_t got);
        mismatches++;
        if (mismatches <= MAX_SHOWN)
            $display("%0t: %s: expected st=%0d len=%0d val=%0d valid=%0d last=%0d, got st=%0d len=%0d val=%0d valid=%0d last=%0d",
                     $time, what, want.status, want.length, want.elem_value, want.elem_valid,
                     want.last, got.status, got.length, got.elem_value, got.elem_valid, got.last);
    endtask

    // input transfers feed the predictor, output transfers are checked
    always @(posedge aclk) begin
        result_t got;
        result_t want;
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results still due", cycles, due_results.size());
            $display("indexed_ordered_list test failed");
            $finish;
        end else if (aresetn) begin
            if (s_tvalid && s_tready) begin
                predict_item(s_tdata[FUNC_W-1:0], s_tdata[FUNC_W +: VALUE_W],
                             int'(s_tdata[FUNC_W+VALUE_W +: INDEX_W]));
                if (cur_fixed) begin
                    void'(due_results.pop_back());
                    due_results.push_back(cur_fixed_res);
                end
                items_taken++;
                if (s_tdata[FUNC_W-1:0] == FUNC_DUMP) dumps_taken++;
                if (cell_count > deepest) deepest = cell_count;
            end
            if (m_tvalid && m_tready) begin
                got.status     = status_t'(m_tdata[1:0]);
                got.length     = m_tdata[6:2];
                got.elem_value = m_tdata[38:7];
                got.elem_valid = m_tdata[39];
                got.last       = m_tlast;
                results_seen++;
                if (got.status != STAT_OK) error_results++;
                if (due_results.size() == 0) begin
                    want = '0;
                    note_failure("unexpected result", want, got);
                end else begin
                    want = due_results.pop_front();
                    if (got !== want) note_failure("mismatch", want, got);
                end
            end
        end
    end

    always @(negedge aclk)
        m_tready <= ($urandom_range(99) >= sink_idle_pct);

    task automatic send_item(input logic [FUNC_W-1:0] func, input logic [VALUE_W-1:0] value,
                             input logic [INDEX_W-1:0] index, input bit fixed,
                             input result_t fixed_res);
        while ($urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        cur_fixed     = fixed;
        cur_fixed_res = fixed_res;
        s_tvalid     <= 1'b1;
        s_tdata      <= {index, value, func};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        @(negedge aclk);
    endtask

    initial begin
        result_t           fixed_res;
        logic [FUNC_W-1:0] func;
        logic [VALUE_W-1:0] value;
        int                index;
        int                k;
        int                rnd_no;
        bit                grow;

        script = '{
            '{FUNC_POP,    0,             0,  1,  1, STAT_EMPTY, 0},
            '{FUNC_REMOVE, 0,             0,  1,  1, STAT_EMPTY, 0},
            '{FUNC_DUMP,   0,             0,  1,  1, STAT_OK,    0},
            '{FUNC_INSERT, 5,             1,  1,  1, STAT_RANGE, 0},
            '{FUNC_LAST,   0,             0,  1,  1, STAT_OK,    0},
            '{FUNC_PUSH,   32'h7fffffff,  0,  1,  1, STAT_OK,    1},
            '{FUNC_INSERT, 32'h80000000,  0,  1,  1, STAT_OK,    2},
            '{FUNC_INSERT, -1,            2,  1,  1, STAT_OK,    3},
            '{FUNC_REMOVE, 0,             3,  1,  1, STAT_RANGE, 3},
            '{FUNC_REMOVE, 0,             31, 1,  1, STAT_RANGE, 3},
            '{FUNC_REMOVE, 0,             1,  1,  1, STAT_OK,    2},
            '{FUNC_PUSH,   32'h55555555,  0,  14, 0, STAT_OK,    0},
            '{FUNC_PUSH,   7,             0,  1,  1, STAT_FULL,  16},
            '{FUNC_INSERT, 7,             31, 1,  1, STAT_FULL,  16},
            '{FUNC_DUMP,   0,             0,  1,  0, STAT_OK,    0},
            '{FUNC_REMOVE, 0,             15, 1,  1, STAT_OK,    15},
            '{FUNC_REMOVE, 0,             0,  1,  1, STAT_OK,    14},
            '{FUNC_POP,    0,             0,  1,  1, STAT_OK,    13},
            '{FUNC_DUMP,   0,             0,  1,  0, STAT_OK,    0}
        };

        src_idle_pct  = 17;
        sink_idle_pct = 58;
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        foreach (script[i]) begin
            for (k = 0; k < script[i].reps; k++) begin
                fixed_res = '{script[i].status, LENGTH_W'(script[i].length), '0, 1'b0, 1'b1};
                send_item(script[i].func, script[i].value + k, INDEX_W'(script[i].index),
                          script[i].fixed, fixed_res);
            end
        end

        // random traffic: alternating grow and shrink episodes so the list fills and drains
        rnd_no = 0;
        for (int phase = 0; phase < 3; phase++) begin
            src_idle_pct  = (phase == 0) ? 17 : (phase == 1) ? 58 : 0;
            sink_idle_pct = (phase == 0) ? 58 : (phase == 1) ? 17 : 0;
            repeat (RANDOM_ITEMS / 3) begin
                grow = ((rnd_no / 32) % 2) == 0;
                k = $urandom_range(99);
                if (k < 8)
                    func = FUNC_DUMP;
                else if (k < 11)
                    func = FUNC_W'($urandom_range(FUNC_DUMP + 1, FUNC_LAST));
                else if (k < 65)
                    func = grow ? ($urandom_range(1) ? FUNC_PUSH : FUNC_INSERT)
                                : ($urandom_range(1) ? FUNC_POP : FUNC_REMOVE);
                else
                    func = FUNC_W'($urandom_range(FUNC_PUSH, FUNC_REMOVE));
                if ($urandom_range(9) == 0)
                    index = $urandom_range(0, 31);
                else if (func == FUNC_INSERT)
                    index = $urandom_range(0, cell_count);
                else
                    index = $urandom_range(0, (cell_count > 0) ? cell_count - 1 : 0);
                case ($urandom_range(7))
                    0:       value = 32'h7fffffff;
                    1:       value = 32'h80000000;
                    default: value = $urandom;
                endcase
                fixed_res = '0;
                send_item(func, value, INDEX_W'(index), 1'b0, fixed_res);
                rnd_no++;
            end
        end
        s_tvalid <= 1'b0;

        while (due_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("covered %0d operations (%0d dumps), %0d results checked, %0d with error status",
                 items_taken, dumps_taken, results_seen, error_results);
        $display("list length reached %0d of %0d; %0d mismatches", deepest, LIST_DEPTH, mismatches);
        if (mismatches == 0)
            $display("indexed_ordered_list test passed");
        else
            $display("indexed_ordered_list test failed");
        $finish;
    end

endmodule

// File: files.f
+incdir+rtl/core
rtl/core/ilst_pkg.sv
rtl/core/ilst_ram.sv
rtl/core/ilst_ctrl.sv
rtl/core/ilst_out.sv
rtl/core/indexed_ordered_list.sv
dv/indexed_ordered_list_test.sv
